/* rtl/rlmc_pkg.sv */
// ----------------------------------------------------------------------------
// rlmc_pkg
// Shared types and constants for the rgb led mode controller.
// ----------------------------------------------------------------------------
package rlmc_pkg;

  localparam int WHEEL_STEPS = 360;
  localparam int MAX_LEVEL   = 120;
  localparam int SEG_STEPS   = WHEEL_STEPS / 3;
  localparam int HUE_W       = $clog2(WHEEL_STEPS);

  localparam int LEVEL_W    = 7;
  localparam int WIDTH_W    = 13;
  localparam int PERIOD_W   = 16;
  localparam int HOLD_W     = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // level * period, then divide by 1000 through a reciprocal
  localparam int PROD_W    = LEVEL_W + PERIOD_W;
  localparam int DIV_MUL_W = 24;
  localparam int DIV_SH    = 33;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd8589935;
  localparam int QUO_W     = PROD_W + DIV_MUL_W - DIV_SH;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [WIDTH_W-1:0] width_t;

  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_WAIT   = 2'd2,
    MODE_ADJUST = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_LOAD = 1'b0,
    CFG_LONG_PRESS  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic b1;
    logic b2;
  } btn_t;

  typedef struct packed {
    mode_t        mode;
    chan_t        channel;
    level_t [2:0] level;
    logic   [2:0] wr;
    logic         plus_one;
  } ctrl_st_t;

endpackage

/* rtl/rlmc_if.sv */
// ----------------------------------------------------------------------------
// rlmc_if
// Valid/ready channels for button words and result words.
// ----------------------------------------------------------------------------
interface rlmc_in_if;
  logic valid;
  logic ready;
  logic button_one_down;
  logic button_two_down;

  modport source (output valid, output button_one_down, output button_two_down,
                  input ready);
  modport sink   (input valid, input button_one_down, input button_two_down,
                  output ready);
endinterface

interface rlmc_out_if import rlmc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [1:0]         channel;
  logic [LEVEL_W-1:0] level_red;
  logic [LEVEL_W-1:0] level_green;
  logic [LEVEL_W-1:0] level_blue;
  logic [WIDTH_W-1:0] width_red;
  logic [WIDTH_W-1:0] width_green;
  logic [WIDTH_W-1:0] width_blue;

  modport source (output valid, output mode, output channel,
                  output level_red, output level_green, output level_blue,
                  output width_red, output width_green, output width_blue,
                  input ready);
  modport sink   (input valid, input mode, input channel,
                  input level_red, input level_green, input level_blue,
                  input width_red, input width_green, input width_blue,
                  output ready);
endinterface

/* rtl/rlmc_ctrl.sv */
// ----------------------------------------------------------------------------
// rlmc_ctrl
// Mode sequencer, colour wheel, key press tracker and level adjust for one word.
// ----------------------------------------------------------------------------
module rlmc_ctrl import rlmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  btn_t              btn,
  input  logic [HOLD_W-1:0] long_press_ticks,
  output ctrl_st_t          st
);

  typedef enum logic [1:0] {
    KEY_IDLE = 2'd0,
    KEY_SEEN = 2'd1,
    KEY_HELD = 2'd2
  } key_t;

  localparam logic [4:0] DWELL_MIN   = 5'd1;
  localparam logic [4:0] DWELL_MAX   = 5'd20;
  localparam logic [4:0] DWELL_RESET = 5'd10;
  localparam level_t     LEVEL_MAX   = LEVEL_W'(MAX_LEVEL);
  localparam logic [LEVEL_W:0] STEP_W   = (LEVEL_W+1)'(10);
  localparam logic [LEVEL_W:0] FLOOR_W  = (LEVEL_W+1)'(10);
  localparam logic [LEVEL_W:0] MAX_W    = (LEVEL_W+1)'(MAX_LEVEL);
  localparam logic [HUE_W-1:0] SEG_A      = HUE_W'(SEG_STEPS);
  localparam logic [HUE_W-1:0] SEG_B      = HUE_W'(2 * SEG_STEPS);
  localparam logic [HUE_W-1:0] WHEEL_LAST = HUE_W'(WHEEL_STEPS - 1);
  localparam int OFFM_W  = HUE_W + LEVEL_W;
  localparam int RISE_SH = 26;
  localparam int RP_W    = OFFM_W + RISE_SH;
  localparam logic [RISE_SH-1:0] RISE_MUL =
    RISE_SH'((2**RISE_SH + SEG_STEPS - 1) / SEG_STEPS);

  mode_t             phase_r, phase_nxt;
  logic [HUE_W-1:0]  hue_r, hue_nxt;
  logic [4:0]        dwell_set_r, dwell_set_nxt;
  logic [4:0]        dwell_cnt_r, dwell_cnt_nxt;
  key_t              key_r, key_nxt;
  logic [HOLD_W-1:0] press_r, press_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  chan_t             chan_r, chan_nxt;
  level_t [2:0]      level_r, level_nxt;
  logic [2:0]        wr_r, wr_nxt;
  logic              plus_r, plus_nxt;
  logic [1:0]        rel_r, rel_nxt;

  logic [1:0]        seg_no;
  logic [HUE_W-1:0]  off;
  logic [OFFM_W-1:0] off_scaled;
  logic [RP_W-1:0]   rise_prod;
  logic [OFFM_W-1:0] rise_q;
  level_t            rise;
  level_t            fall;
  level_t [2:0]      wheel_lvl;
  logic [5:0]        cnt_inc;
  logic [1:0]        ch_idx;
  logic [LEVEL_W:0]  adj;

  // colour wheel position to levels
  always_comb begin
    if (hue_r >= SEG_B) begin
      seg_no = 2'd2;
      off    = hue_r - SEG_B;
    end else if (hue_r >= SEG_A) begin
      seg_no = 2'd1;
      off    = hue_r - SEG_A;
    end else begin
      seg_no = 2'd0;
      off    = hue_r;
    end
    off_scaled = OFFM_W'(off) * OFFM_W'(MAX_LEVEL);
    rise_prod  = RP_W'(off_scaled) * RP_W'(RISE_MUL);
    rise_q     = rise_prod[RP_W-1:RISE_SH];
    rise       = (rise_q > OFFM_W'(MAX_LEVEL)) ? LEVEL_MAX : rise_q[LEVEL_W-1:0];
    fall       = LEVEL_MAX - rise;
    case (seg_no)
      2'd0: begin
        wheel_lvl[0] = fall;
        wheel_lvl[1] = rise;
        wheel_lvl[2] = '0;
      end
      2'd1: begin
        wheel_lvl[0] = '0;
        wheel_lvl[1] = fall;
        wheel_lvl[2] = rise;
      end
      default: begin
        wheel_lvl[0] = rise;
        wheel_lvl[1] = '0;
        wheel_lvl[2] = fall;
      end
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    hue_nxt       = hue_r;
    dwell_set_nxt = dwell_set_r;
    dwell_cnt_nxt = dwell_cnt_r;
    key_nxt       = key_r;
    press_nxt     = press_r;
    hold_nxt      = hold_r;
    chan_nxt      = chan_r;
    level_nxt     = level_r;
    wr_nxt        = '0;
    plus_nxt      = 1'b0;
    rel_nxt       = rel_r;
    cnt_inc       = {1'b0, dwell_cnt_r} + 6'd1;
    adj           = '0;
    case (chan_r)
      CH_RED:   ch_idx = 2'd0;
      CH_GREEN: ch_idx = 2'd1;
      default:  ch_idx = 2'd2;
    endcase

    case (phase_r)
      MODE_AUTO: begin
        if (btn.b1 && btn.b2) begin
          phase_nxt = MODE_SELECT;
          key_nxt   = KEY_SEEN;
          press_nxt = '0;
          hold_nxt  = '0;
        end else begin
          level_nxt = wheel_lvl;
          if (btn.b1 && dwell_set_nxt > DWELL_MIN) dwell_set_nxt = dwell_set_nxt - 5'd1;
          if (btn.b2 && dwell_set_nxt < DWELL_MAX) dwell_set_nxt = dwell_set_nxt + 5'd1;
          wr_nxt   = '1;
          plus_nxt = 1'b1;
          if (cnt_inc >= {1'b0, dwell_set_nxt}) begin
            dwell_cnt_nxt = '0;
            hue_nxt       = (hue_r == WHEEL_LAST) ? '0 : hue_r + HUE_W'(1);
          end else begin
            dwell_cnt_nxt = cnt_inc[4:0];
          end
        end
      end
      MODE_SELECT: begin
        case (key_r)
          KEY_SEEN: begin
            if (btn.b1) begin
              key_nxt = KEY_HELD;
              if (press_r != '1) press_nxt = press_r + HOLD_W'(1);
            end
          end
          KEY_HELD: begin
            if (!btn.b1) key_nxt = KEY_IDLE;
          end
          default: begin
            key_nxt = btn.b1 ? KEY_SEEN : KEY_IDLE;
          end
        endcase
        if (key_nxt == KEY_HELD) begin
          hold_nxt = (hold_r == '1) ? hold_r : hold_r + HOLD_W'(1);
        end else begin
          hold_nxt = '0;
        end
        if (hold_nxt > long_press_ticks) begin
          phase_nxt = MODE_WAIT;
        end else if (!btn.b1 && !btn.b2) begin
          phase_nxt = MODE_ADJUST;
          chan_nxt  = (press_nxt == HOLD_W'(1)) ? CH_RED : CH_BLUE;
          rel_nxt   = '0;
        end
      end
      MODE_WAIT: begin
        if (!btn.b1 && !btn.b2) begin
          phase_nxt = MODE_ADJUST;
          chan_nxt  = CH_GREEN;
          rel_nxt   = '0;
        end
      end
      default: begin
        if (btn.b1 && btn.b2) begin
          phase_nxt = MODE_SELECT;
          key_nxt   = KEY_SEEN;
          press_nxt = '0;
          hold_nxt  = '0;
        end else begin
          adj = {1'b0, level_r[ch_idx]};
          if (!btn.b1 && rel_r[0]) begin
            adj = (adj <= FLOOR_W + STEP_W) ? FLOOR_W : adj - STEP_W;
            wr_nxt[ch_idx] = 1'b1;
          end
          if (!btn.b2 && rel_r[1]) begin
            adj = (adj + STEP_W > MAX_W) ? MAX_W : adj + STEP_W;
            wr_nxt[ch_idx] = 1'b1;
          end
          level_nxt[ch_idx] = adj[LEVEL_W-1:0];
          rel_nxt = {btn.b2, btn.b1};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= MODE_AUTO;
      hue_r       <= '0;
      dwell_set_r <= DWELL_RESET;
      dwell_cnt_r <= '0;
      key_r       <= KEY_IDLE;
      press_r     <= '0;
      hold_r      <= '0;
      chan_r      <= CH_RED;
      level_r[0]  <= LEVEL_MAX;
      level_r[1]  <= '0;
      level_r[2]  <= '0;
      wr_r        <= '0;
      plus_r      <= 1'b0;
      rel_r       <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      hue_r       <= hue_nxt;
      dwell_set_r <= dwell_set_nxt;
      dwell_cnt_r <= dwell_cnt_nxt;
      key_r       <= key_nxt;
      press_r     <= press_nxt;
      hold_r      <= hold_nxt;
      chan_r      <= chan_nxt;
      level_r     <= level_nxt;
      wr_r        <= wr_nxt;
      plus_r      <= plus_nxt;
      rel_r       <= rel_nxt;
    end
  end

  assign st.mode     = phase_r;
  assign st.channel  = chan_r;
  assign st.level    = level_r;
  assign st.wr       = wr_r;
  assign st.plus_one = plus_r;

  a_no_return: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != MODE_AUTO) |=> (phase_r != MODE_AUTO))
    else $error("auto mode re-entered");

  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r[0] <= LEVEL_MAX) && (level_r[1] <= LEVEL_MAX) && (level_r[2] <= LEVEL_MAX))
    else $error("level above maximum");

  a_hold_key: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r != '0) |-> (key_r == KEY_HELD))
    else $error("hold count without held key");

endmodule

/* rtl/rlmc_width.sv */
// ----------------------------------------------------------------------------
// rlmc_width
// Pulse width of one channel: level times period, divided by 1000, saturated.
// ----------------------------------------------------------------------------
module rlmc_width import rlmc_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  level_t              level,
  input  logic [PERIOD_W-1:0] period,
  output width_t              width
);

  localparam int QP_W = PROD_W + DIV_MUL_W;

  logic [PROD_W-1:0] prod_r;
  logic [QP_W-1:0]   quo_prod;
  logic [QUO_W-1:0]  quo;

  always_ff @(posedge clk) begin
    if (en) prod_r <= PROD_W'(level) * PROD_W'(period);
  end

  // reciprocal of 1000, exact over the product range
  assign quo_prod = QP_W'(prod_r) * QP_W'(DIV_MUL);
  assign quo      = quo_prod[QP_W-1:DIV_SH];
  assign width    = (quo > QUO_W'(WIDTH_MAX)) ? WIDTH_MAX : quo[WIDTH_W-1:0];

endmodule

/* rtl/rgb_led_mode_controller.sv */
// ----------------------------------------------------------------------------
// rgb_led_mode_controller
// Two-button rgb led controller: colour wheel, channel select, level adjust.
// ----------------------------------------------------------------------------
// Takes one button word per clock and returns one result word for each, in
// order. A word passes four registers: the input register, the mode and level
// state, the level-times-period product of each channel and the result
// register, and a new word is taken every cycle while the result side keeps
// up. When a result waits, the whole pipeline holds and in ready drops.
// Configuration writes take effect at once and no start-up pass is needed
// after reset.
// ----------------------------------------------------------------------------
module rgb_led_mode_controller import rlmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rlmc_in_if.sink               in_if,
  rlmc_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PERIOD_W-1:0] period_r;
  logic [HOLD_W-1:0]   long_r;
  logic                v0_r, v1_r, v2_r, v3_r;
  logic                en;
  logic                accept;
  btn_t                btn_r;
  ctrl_st_t            st;
  ctrl_st_t            st2_r;
  ctrl_st_t            out_st_r;
  width_t [2:0]        quo;
  width_t [2:0]        quo_inc;
  width_t [2:0]        widths_r;

  assign en          = !v3_r || out_if.ready;
  assign accept      = in_if.valid && en;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_W'(11362);
      long_r   <= HOLD_W'(10);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PERIOD_LOAD: period_r <= cfg_data[PERIOD_W-1:0];
        CFG_LONG_PRESS:  long_r   <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      btn_r.b1 <= in_if.button_one_down;
      btn_r.b2 <= in_if.button_two_down;
    end
    if (en) st2_r <= st;
  end

  rlmc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (v0_r && en),
    .btn              (btn_r),
    .long_press_ticks (long_r),
    .st               (st)
  );

  for (genvar i = 0; i < 3; i++) begin : g_width
    rlmc_width u_width (
      .clk    (clk),
      .en     (en),
      .level  (st.level[i]),
      .period (period_r),
      .width  (quo[i])
    );
    assign quo_inc[i] = (quo[i] == WIDTH_MAX) ? WIDTH_MAX : quo[i] + WIDTH_W'(1);
  end

  // pulse widths persist between words, so they carry a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widths_r <= '0;
    end else if (en && v2_r) begin
      for (int i = 0; i < 3; i++) begin
        if (st2_r.wr[i]) widths_r[i] <= st2_r.plus_one ? quo_inc[i] : quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v2_r) out_st_r <= st2_r;
  end

  assign out_if.valid       = v3_r;
  assign out_if.mode        = out_st_r.mode;
  assign out_if.channel     = out_st_r.channel;
  assign out_if.level_red   = out_st_r.level[0];
  assign out_if.level_green = out_st_r.level[1];
  assign out_if.level_blue  = out_st_r.level[2];
  assign out_if.width_red   = widths_r[0];
  assign out_if.width_green = widths_r[1];
  assign out_if.width_blue  = widths_r[2];

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("word taken while result stalled");

endmodule
